@@ design/pid_line_follow_drive_top_macros.svh @@
// Assertion macros for the line-follow PID drive block.
// Used by the port checker; expects aclk and aresetn in the scope of each use.
`ifndef PID_LINE_FOLLOW_DRIVE_TOP_MACROS_SVH
`define PID_LINE_FOLLOW_DRIVE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PLFD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PLFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/plfd_pkg.sv @@
// Shared types and constants of the line-follow PID drive block.
// No dependencies; imported by every module of the block.
package plfd_pkg;

    // Field widths
    localparam int SAMPLE_W   = 12;
    localparam int ERR_W      = 13;
    localparam int DIFF_W     = 14;
    localparam int SUM_W      = 32;
    localparam int GAIN_W     = 28;
    localparam int SPEED_W    = 8;
    localparam int LR_W       = 10;
    localparam int CORR_W     = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 32;

    // The scale factors 2000 and 2000000 are split into a small odd
    // multiplier and a power of two: 2000 = 125 * 2^4, 2000000 = 15625 * 2^7.
    localparam int ERR_SCALE = 125;
    localparam int P_SHIFT   = 4;
    localparam int D_SCALE   = 15625;
    localparam int D_SHIFT   = 7;

    // Widths of the scaled error terms and of the gain products
    localparam int ERR_P_W  = 20;
    localparam int DIFF_D_W = 28;
    localparam int PROD_P_W = 48;
    localparam int PROD_I_W = 60;
    localparam int PROD_D_W = 56;
    localparam int NUM_W    = 64;

    // Division of the numerator by 2000 * 2^24, truncated toward zero.
    // The quotient below the clamp limits is found from |num| >> 24 with a
    // reciprocal of 2000, exact for every magnitude under 2^19.
    localparam int DIV_SHIFT   = 24;
    localparam int CORR_DIV    = 2000;
    localparam int MAG_W       = 19;
    localparam int RECIP_K     = 536871;
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 30;
    localparam int Q_W         = 8;

    // Clamp limits of the correction
    localparam int CORR_MIN     = -150;
    localparam int CORR_MAX     = 50;
    localparam int CORR_NEG_LIM = 150;
    localparam logic [NUM_W-1:0] POS_SAT_MAG =
        (NUM_W'(CORR_MAX) * NUM_W'(CORR_DIV)) << DIV_SHIFT;
    localparam logic [NUM_W-1:0] NEG_SAT_MAG =
        (NUM_W'(CORR_NEG_LIM) * NUM_W'(CORR_DIV)) << DIV_SHIFT;

    // Error sum saturation limits
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Register reset values
    localparam logic                  RST_TRACK_SIDE   = 1'b1;
    localparam logic [SAMPLE_W-1:0]   RST_TARGET       = 12'd250;
    localparam logic [GAIN_W-1:0]     RST_GAIN_P       = 28'd5033165;
    localparam logic [GAIN_W-1:0]     RST_GAIN_I       = 28'd1677722;
    localparam logic [GAIN_W-1:0]     RST_GAIN_D       = 28'd839;
    localparam logic [SPEED_W-1:0]    RST_CRUISE_SPEED = 8'd60;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRACK_SIDE   = 3'd0,
        CFG_TARGET_LEVEL = 3'd1,
        CFG_GAIN_P       = 3'd2,
        CFG_GAIN_I       = 3'd3,
        CFG_GAIN_D       = 3'd4,
        CFG_CRUISE_SPEED = 3'd5
    } cfg_index_t;

    // Configuration register set
    typedef struct packed {
        logic                track_side;
        logic [SAMPLE_W-1:0] target_level;
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_i;
        logic [GAIN_W-1:0]   gain_d;
        logic [SPEED_W-1:0]  cruise_speed;
    } cfg_t;

    // Incoming request
    typedef struct packed {
        logic                clear_history;
        logic [SAMPLE_W-1:0] sensor_sample;
    } in_item_t;

    // Scaled error terms and updated sum
    typedef struct packed {
        logic signed [ERR_P_W-1:0]  err_p;
        logic signed [DIFF_D_W-1:0] diff_d;
        logic signed [SUM_W-1:0]    sum;
    } err_item_t;

    // Gain products
    typedef struct packed {
        logic signed [PROD_P_W-1:0] prod_p;
        logic signed [PROD_I_W-1:0] prod_i;
        logic signed [PROD_D_W-1:0] prod_d;
    } prod_item_t;

    // Result request, packed as on the result bus (left in the lowest bits)
    typedef struct packed {
        logic signed [CORR_W-1:0] correction;
        logic signed [LR_W-1:0]   right_drive;
        logic signed [LR_W-1:0]   left_drive;
    } out_item_t;

endpackage

@@ design/plfd_cfg.sv @@
// Configuration register file of the line-follow PID drive block.
// Depends on plfd_pkg for the register set type, indexes and reset values.
module plfd_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [plfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [plfd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output plfd_pkg::cfg_t                   cfg
);
    import plfd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Next value of the register set
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TRACK_SIDE:   cfg_next.track_side   = cfg_data[0];
                CFG_TARGET_LEVEL: cfg_next.target_level = cfg_data[SAMPLE_W-1:0];
                CFG_GAIN_P:       cfg_next.gain_p       = cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:       cfg_next.gain_i       = cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:       cfg_next.gain_d       = cfg_data[GAIN_W-1:0];
                CFG_CRUISE_SPEED: cfg_next.cruise_speed = cfg_data[SPEED_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // Register set with its reset values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.track_side   <= RST_TRACK_SIDE;
            cfg_reg.target_level <= RST_TARGET;
            cfg_reg.gain_p       <= RST_GAIN_P;
            cfg_reg.gain_i       <= RST_GAIN_I;
            cfg_reg.gain_d       <= RST_GAIN_D;
            cfg_reg.cruise_speed <= RST_CRUISE_SPEED;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ design/plfd_err.sv @@
// Input register and error history stage of the line-follow PID drive block.
// Depends on plfd_pkg; keeps the previous error and the saturating error sum.
module plfd_err (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  plfd_pkg::in_item_t             s_item,
    input  logic [plfd_pkg::SAMPLE_W-1:0]  target_level,
    output logic                           e_valid,
    input  logic                           e_ready,
    output plfd_pkg::err_item_t            e_item
);
    import plfd_pkg::*;

    logic      in_valid_reg;
    logic      in_valid_next;
    in_item_t  in_item_reg;
    logic      e_valid_reg;
    logic      e_valid_next;
    err_item_t e_item_reg;
    err_item_t e_item_next;

    logic signed [ERR_W-1:0] prev_error_reg;
    logic signed [SUM_W-1:0] error_sum_reg;

    logic                       e_load;
    logic                       advance;
    logic signed [ERR_W-1:0]    prev_eff;
    logic signed [SUM_W-1:0]    sum_eff;
    logic signed [ERR_W-1:0]    err_c;
    logic signed [DIFF_W-1:0]   diff_c;
    logic signed [SUM_W+1:0]    sum_wide;
    logic signed [SUM_W-1:0]    sum_sat;
    logic signed [ERR_P_W-1:0]  err_x;
    logic signed [DIFF_D_W-1:0] diff_x;

    // Handshake: the input register refills as soon as its request moves on.
    assign e_load        = !e_valid_reg || e_ready;
    assign advance       = in_valid_reg && e_load;
    assign s_ready       = !in_valid_reg || e_load;
    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !e_load);
    assign e_valid_next  = advance || (e_valid_reg && !e_ready);
    assign e_valid       = e_valid_reg;
    assign e_item        = e_item_reg;

    // A clear request sees an empty history.
    assign prev_eff = in_item_reg.clear_history ? '0 : prev_error_reg;
    assign sum_eff  = in_item_reg.clear_history ? '0 : error_sum_reg;

    // Error, difference and trapezoidal sum
    assign err_c  = $signed({1'b0, in_item_reg.sensor_sample}) - $signed({1'b0, target_level});
    assign diff_c = {err_c[ERR_W-1], err_c} - {prev_eff[ERR_W-1], prev_eff};
    assign sum_wide = {{2{sum_eff[SUM_W-1]}}, sum_eff}
                    + {{(SUM_W+2-ERR_W){err_c[ERR_W-1]}}, err_c}
                    + {{(SUM_W+2-ERR_W){prev_eff[ERR_W-1]}}, prev_eff};

    // Saturate the sum to 32 bits
    always_comb begin
        if (sum_wide[SUM_W+1:SUM_W-1] == 3'b000 || sum_wide[SUM_W+1:SUM_W-1] == 3'b111) begin
            sum_sat = sum_wide[SUM_W-1:0];
        end else if (sum_wide[SUM_W+1]) begin
            sum_sat = SUM_MIN;
        end else begin
            sum_sat = SUM_MAX;
        end
    end

    // Pre-scale error and difference by the odd parts of 2000 and 2000000
    assign err_x  = {{(ERR_P_W-ERR_W){err_c[ERR_W-1]}}, err_c};
    assign diff_x = {{(DIFF_D_W-DIFF_W){diff_c[DIFF_W-1]}}, diff_c};

    always_comb begin
        e_item_next.err_p  = err_x * $signed(ERR_P_W'(ERR_SCALE));
        e_item_next.diff_d = diff_x * $signed(DIFF_D_W'(D_SCALE));
        e_item_next.sum    = sum_sat;
    end

    // Control registers and history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            e_valid_reg    <= 1'b0;
            prev_error_reg <= '0;
            error_sum_reg  <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            e_valid_reg  <= e_valid_next;
            if (advance) begin
                prev_error_reg <= err_c;
                error_sum_reg  <= sum_sat;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            e_item_reg <= e_item_next;
        end
    end

endmodule

@@ design/plfd_mult.sv @@
// Gain multiplier stage of the line-follow PID drive block.
// Depends on plfd_pkg; forms the three gain products of one request.
module plfd_mult (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         e_valid,
    output logic                         e_ready,
    input  plfd_pkg::err_item_t          e_item,
    input  logic [plfd_pkg::GAIN_W-1:0]  gain_p,
    input  logic [plfd_pkg::GAIN_W-1:0]  gain_i,
    input  logic [plfd_pkg::GAIN_W-1:0]  gain_d,
    output logic                         p_valid,
    input  logic                         p_ready,
    output plfd_pkg::prod_item_t         p_item
);
    import plfd_pkg::*;

    logic       p_valid_reg;
    logic       p_valid_next;
    prod_item_t p_item_reg;
    prod_item_t p_item_next;
    logic       p_load;

    assign p_load       = !p_valid_reg || p_ready;
    assign e_ready      = p_load;
    assign p_valid_next = p_load ? e_valid : p_valid_reg;
    assign p_valid      = p_valid_reg;
    assign p_item       = p_item_reg;

    // Unsigned gains times signed terms
    always_comb begin
        p_item_next.prod_p = $signed({1'b0, gain_p}) * e_item.err_p;
        p_item_next.prod_i = $signed({1'b0, gain_i}) * e_item.sum;
        p_item_next.prod_d = $signed({1'b0, gain_d}) * e_item.diff_d;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= p_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_load && e_valid) begin
            p_item_reg <= p_item_next;
        end
    end

endmodule

@@ design/plfd_post.sv @@
// Sum, divide, clamp and wheel mix stages of the line-follow PID drive block.
// Depends on plfd_pkg; three register stages ending in the result register.
module plfd_post (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          p_valid,
    output logic                          p_ready,
    input  plfd_pkg::prod_item_t          p_item,
    input  logic                          track_side,
    input  logic [plfd_pkg::SPEED_W-1:0]  cruise_speed,
    output logic                          m_valid,
    input  logic                          m_ready,
    output plfd_pkg::out_item_t           m_item
);
    import plfd_pkg::*;

    // Stage control
    logic v_num_reg;
    logic v_mag_reg;
    logic v_out_reg;
    logic load_num;
    logic load_mag;
    logic load_out;

    // Stage payloads
    logic signed [NUM_W-1:0] num_reg;
    logic                    neg_reg;
    logic                    pos_sat_reg;
    logic                    neg_sat_reg;
    logic [MAG_W-1:0]        m_mag_reg;
    out_item_t               out_reg;

    // Combinational values
    logic signed [NUM_W-1:0]   p_w;
    logic signed [NUM_W-1:0]   i_w;
    logic signed [NUM_W-1:0]   d_w;
    logic signed [NUM_W-1:0]   num_next;
    logic [NUM_W-1:0]          mag_c;
    logic [MAG_W+RECIP_W-1:0]  recip_prod;
    logic [Q_W-1:0]            quot;
    logic signed [CORR_W-1:0]  quot_s;
    logic signed [CORR_W-1:0]  corr_c;
    logic signed [LR_W-1:0]    base_x;
    logic signed [LR_W-1:0]    corr_x;
    out_item_t                 out_next;

    assign load_out = !v_out_reg || m_ready;
    assign load_mag = !v_mag_reg || load_out;
    assign load_num = !v_num_reg || load_mag;
    assign p_ready  = load_num;
    assign m_valid  = v_out_reg;
    assign m_item   = out_reg;

    // Numerator: 2000*gp*e + gi*S + 2000000*gd*(e - e_prev)
    assign p_w = {{(NUM_W-PROD_P_W){p_item.prod_p[PROD_P_W-1]}}, p_item.prod_p};
    assign i_w = {{(NUM_W-PROD_I_W){p_item.prod_i[PROD_I_W-1]}}, p_item.prod_i};
    assign d_w = {{(NUM_W-PROD_D_W){p_item.prod_d[PROD_D_W-1]}}, p_item.prod_d};
    assign num_next = (p_w <<< P_SHIFT) + i_w + (d_w <<< D_SHIFT);

    // Magnitude of the numerator
    assign mag_c = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);

    // Quotient by 2000 through the reciprocal, then sign and clamp
    assign recip_prod = (MAG_W+RECIP_W)'(m_mag_reg) * (MAG_W+RECIP_W)'(RECIP_K);
    assign quot       = recip_prod[RECIP_SHIFT +: Q_W];
    assign quot_s     = $signed({1'b0, quot});

    always_comb begin
        priority if (neg_sat_reg) begin
            corr_c = CORR_W'(CORR_MIN);
        end else if (pos_sat_reg) begin
            corr_c = CORR_W'(CORR_MAX);
        end else if (neg_reg) begin
            corr_c = -quot_s;
        end else begin
            corr_c = quot_s;
        end
    end

    // Wheel mix; the sign follows the tracked side
    assign base_x = $signed({2'b00, cruise_speed});
    assign corr_x = {corr_c[CORR_W-1], corr_c};

    always_comb begin
        out_next.correction = corr_c;
        if (track_side) begin
            out_next.left_drive  = base_x + corr_x;
            out_next.right_drive = base_x - corr_x;
        end else begin
            out_next.left_drive  = base_x - corr_x;
            out_next.right_drive = base_x + corr_x;
        end
    end

    // Stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_num_reg <= 1'b0;
            v_mag_reg <= 1'b0;
            v_out_reg <= 1'b0;
        end else begin
            if (load_num) begin
                v_num_reg <= p_valid;
            end
            if (load_mag) begin
                v_mag_reg <= v_num_reg;
            end
            if (load_out) begin
                v_out_reg <= v_mag_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        if (load_num && p_valid) begin
            num_reg <= num_next;
        end
        if (load_mag && v_num_reg) begin
            neg_reg     <= num_reg[NUM_W-1];
            pos_sat_reg <= !num_reg[NUM_W-1] && (mag_c >= POS_SAT_MAG);
            neg_sat_reg <= num_reg[NUM_W-1] && (mag_c >= NEG_SAT_MAG);
            m_mag_reg   <= mag_c[DIV_SHIFT +: MAG_W];
        end
        if (load_out && v_mag_reg) begin
            out_reg <= out_next;
        end
    end

endmodule

@@ design/pid_line_follow_drive_top.sv @@
// Line-follow PID wheel-speed controller: one reflectance sample in, one
// correction and pair of wheel speeds out per request, one request per cycle
// sustained unless the output stalls. A sample passes the input register,
// error history, gain multiply, sum, magnitude, divide and mix registers;
// feedback is the previous error and 32-bit saturating error sum of the error
// history stage. cfg_ready is always high; registers must be written while
// no request is in flight, not enforced. Depends on plfd_pkg and submodules.
module pid_line_follow_drive_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Sample requests
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [11:0] sensor_sample, [12] clear_history, [15:13] zero
    input  logic [plfd_pkg::S_TDATA_W-1:0]    s_tdata,
    // Results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [9:0] left wheel drive, [19:10] right wheel drive, [28:20] correction,
    // [31:29] zero
    output logic [plfd_pkg::M_TDATA_W-1:0]    m_tdata,
    // Register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [plfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [plfd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import plfd_pkg::*;

    cfg_t       cfg;
    in_item_t   s_item;
    logic       e_valid;
    logic       e_ready;
    err_item_t  e_item;
    logic       p_valid;
    logic       p_ready;
    prod_item_t p_item;
    out_item_t  m_item;

    // Unpack the sample request and pack the result
    assign s_item.sensor_sample = s_tdata[SAMPLE_W-1:0];
    assign s_item.clear_history = s_tdata[SAMPLE_W];
    assign m_tdata = {{(M_TDATA_W-$bits(out_item_t)){1'b0}}, m_item};

    plfd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    plfd_err u_err (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .s_item       (s_item),
        .target_level (cfg.target_level),
        .e_valid      (e_valid),
        .e_ready      (e_ready),
        .e_item       (e_item)
    );

    plfd_mult u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .e_valid (e_valid),
        .e_ready (e_ready),
        .e_item  (e_item),
        .gain_p  (cfg.gain_p),
        .gain_i  (cfg.gain_i),
        .gain_d  (cfg.gain_d),
        .p_valid (p_valid),
        .p_ready (p_ready),
        .p_item  (p_item)
    );

    plfd_post u_post (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .p_valid      (p_valid),
        .p_ready      (p_ready),
        .p_item       (p_item),
        .track_side   (cfg.track_side),
        .cruise_speed (cfg.cruise_speed),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_item       (m_item)
    );

endmodule

@@ design/plfd_checker.sv @@
// Port checker for the line-follow PID drive block, bound to the top level.
// Depends on plfd_pkg and the assertion macros header.
`include "pid_line_follow_drive_top_macros.svh"

module plfd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [plfd_pkg::M_TDATA_W-1:0]  m_tdata
);
    import plfd_pkg::*;

    logic signed [LR_W-1:0]   left_w;
    logic signed [LR_W-1:0]   right_w;
    logic signed [CORR_W-1:0] corr_w;
    logic signed [LR_W+1:0]   lr_diff;
    logic signed [LR_W+1:0]   corr_dbl;

    // Result fields as seen on the bus
    assign left_w   = m_tdata[LR_W-1:0];
    assign right_w  = m_tdata[2*LR_W-1:LR_W];
    assign corr_w   = m_tdata[2*LR_W+CORR_W-1:2*LR_W];
    assign lr_diff  = left_w - right_w;
    assign corr_dbl = {{2{corr_w[CORR_W-1]}}, corr_w, 1'b0};

    // A stalled result stays valid and unchanged.
    `PLFD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // The correction stays within its clamp limits.
    `PLFD_ASSERT_SAME(a_corr_range, m_tvalid, corr_w >= CORR_W'(CORR_MIN) && corr_w <= CORR_W'(CORR_MAX), "correction outside clamp limits")

    // The two wheels differ by twice the correction in one sense or the other.
    `PLFD_ASSERT_SAME(a_mix, m_tvalid, lr_diff == corr_dbl || lr_diff == -corr_dbl, "wheel speeds do not match correction")

    // Nothing is offered straight after reset.
    `PLFD_ASSERT_SAME(a_reset_empty, $past(!aresetn), !m_tvalid, "result valid straight after reset")

endmodule

bind pid_line_follow_drive_top plfd_checker u_plfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
